[hdl/rbei_pkg.sv]
// ----------------------------------------------------------------------------
// rbei_pkg: shared constants and types for the rigid body integrator.
// Holds command codes, register indexes, fixed constants and the angle table.
// ----------------------------------------------------------------------------
package rbei_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_TABLE_LEN  = 24;
    localparam int PW               = 32;
    localparam int ACC              = 2 * PW + 1;

    localparam logic [30:0] INV_MASS_RST    = 31'd3277;
    localparam logic [30:0] INV_INERTIA_RST = 31'd3277;
    localparam logic [16:0] TIME_STEP_RST   = 17'd1092;

    localparam logic [31:0] TURN_SCALE  = 32'd683565276;
    localparam logic [31:0] SPIN_DECAY  = 32'd58514;
    localparam logic [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_FORCE   = 2'd1,
        CMD_IMPULSE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_INV_MASS    = 2'd0,
        REG_INV_INERTIA = 2'd1,
        REG_TIME_STEP   = 2'd2
    } t_reg;

    // Multiplier request: operands, signedness flag and start strobe.
    typedef struct packed {
        logic            start;
        logic [PW-1:0]   a;
        logic [PW-1:0]   b;
        logic            a_signed;
    } t_mul_req;

    typedef struct packed {
        logic            done;
        logic [ACC-1:0]  prod;
    } t_mul_rsp;

    function automatic logic [33:0] angle_step(input logic [4:0] i);
        logic [33:0] v;
        case (i)
            5'd0:  v = 34'd536870912;
            5'd1:  v = 34'd316933406;
            5'd2:  v = 34'd167458907;
            5'd3:  v = 34'd85004756;
            5'd4:  v = 34'd42667331;
            5'd5:  v = 34'd21354465;
            5'd6:  v = 34'd10679838;
            5'd7:  v = 34'd5340245;
            5'd8:  v = 34'd2670163;
            5'd9:  v = 34'd1335087;
            5'd10: v = 34'd667544;
            5'd11: v = 34'd333772;
            5'd12: v = 34'd166886;
            5'd13: v = 34'd83443;
            5'd14: v = 34'd41722;
            5'd15: v = 34'd20861;
            5'd16: v = 34'd10430;
            5'd17: v = 34'd5215;
            5'd18: v = 34'd2608;
            5'd19: v = 34'd1304;
            5'd20: v = 34'd652;
            5'd21: v = 34'd326;
            5'd22: v = 34'd163;
            5'd23: v = 34'd81;
            default: v = 34'd0;
        endcase
        return v;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [ACC-1:0] v);
        if (v > $signed({{(ACC-32){1'b0}}, 32'h7fffffff}))
            return 32'h7fffffff;
        else if (v < $signed({{(ACC-32){1'b1}}, 32'h80000000}))
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

endpackage

[hdl/rbei_mul.sv]
// ----------------------------------------------------------------------------
// rbei_mul: bit-serial shift-add multiplier.
// Multiplies a 32-bit value by a 32-bit value, one multiplier bit per cycle,
// giving an exact 65-bit product. With a_signed both operands are signed;
// without it both are unsigned.
// ----------------------------------------------------------------------------
module rbei_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbei_pkg::t_mul_req   i_req,
    output rbei_pkg::t_mul_rsp   o_rsp
);
    localparam int PW  = rbei_pkg::PW;
    localparam int ACC = rbei_pkg::ACC;

    logic              r_busy, n_busy;
    logic [5:0]        r_cnt, n_cnt;
    logic [ACC-1:0]    r_acc, n_acc;
    logic [ACC-1:0]    r_mcand, n_mcand;
    logic [PW-1:0]     r_mplier, n_mplier;
    logic              r_sgn, n_sgn;
    logic              r_done, n_done;

    // One multiplier bit per cycle; the top bit of a signed operand subtracts.
    always_comb begin
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_sgn    = r_sgn;
        n_done   = 1'b0;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_cnt    = 6'd0;
            n_acc    = '0;
            n_mcand  = {{(ACC-PW){i_req.a_signed & i_req.a[PW-1]}}, i_req.a};
            n_mplier = i_req.b;
            n_sgn    = i_req.a_signed;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                if (r_sgn && r_cnt == 6'(PW - 1))
                    n_acc = r_acc - r_mcand;
                else
                    n_acc = r_acc + r_mcand;
            end
            n_mcand  = {r_mcand[ACC-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[PW-1:1]};
            n_cnt    = r_cnt + 6'd1;
            if (r_cnt == 6'(PW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_sgn    <= n_sgn;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    // A product appears only after a running multiply finishes.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("multiplier done without a running multiply");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < 6'(PW))
        else $error("multiplier count overran");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("multiplier busy and done together");

endmodule

[hdl/rbei_cordic.sv]
// ----------------------------------------------------------------------------
// rbei_cordic: iterative rotation-mode CORDIC.
// Takes a 32-bit binary angle and returns cos and sin in Q1.16, one
// iteration per cycle.
// ----------------------------------------------------------------------------
module rbei_cordic #(
    parameter int CORDIC_STEPS = rbei_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_angle,
    output logic                o_done,
    output logic signed [17:0]  o_cos,
    output logic signed [17:0]  o_sin
);
    localparam int NSTEP = (CORDIC_STEPS < rbei_pkg::ANGLE_TABLE_LEN) ?
                           CORDIC_STEPS : rbei_pkg::ANGLE_TABLE_LEN;

    logic                r_busy, r_done, r_neg;
    logic [4:0]          r_i;
    logic signed [33:0]  r_x, r_y, r_z;
    logic signed [33:0]  w_xs, w_ys, w_x, w_y, w_c, w_s;
    logic [31:0]         w_b;
    logic                w_fold;
    logic signed [19:0]  w_cr, w_sr;

    assign w_fold = (i_angle > 32'h40000000) && (i_angle < 32'hc0000000);
    assign w_b    = w_fold ? i_angle + 32'h80000000 : i_angle;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= rbei_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= {{2{w_b[31]}}, w_b};
                r_neg  <= w_fold;
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - $signed(rbei_pkg::angle_step(r_i));
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + $signed(rbei_pkg::angle_step(r_i));
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Round to 16 fraction bits, clamp to one, then undo the half-turn fold.
    assign w_x  = (r_x + 34'sd8192) >>> 14;
    assign w_y  = (r_y + 34'sd8192) >>> 14;
    assign w_c  = (w_x > 34'sd65536) ? 34'sd65536 : (w_x < -34'sd65536) ? -34'sd65536 : w_x;
    assign w_s  = (w_y > 34'sd65536) ? 34'sd65536 : (w_y < -34'sd65536) ? -34'sd65536 : w_y;
    assign w_cr = r_neg ? -w_c[19:0] : w_c[19:0];
    assign w_sr = r_neg ? -w_s[19:0] : w_s[19:0];
    assign o_cos  = w_cr[17:0];
    assign o_sin  = w_sr[17:0];
    assign o_done = r_done;

    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("cordic done without running");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_i < 5'(NSTEP))
        else $error("cordic step overran");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("cordic started while running");

endmodule

[hdl/rigid_body_euler_integrator.sv]
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator: 2D rigid body state with semi-implicit Euler.
// A force item adds to the force accumulators, an impulse item updates velocity and spin;
// a tick integrates and recomputes the rotation with a shared serial multiplier and CORDIC.
// ----------------------------------------------------------------------------
// A force or unused item gives its result without the multiplier; an impulse item runs
// five multiplies, and a tick runs nine multiplies with a CORDIC rotation before the last,
// all on one bit-serial multiplier. Throughput: one item at a time; the next is accepted
// in S_IDLE, after the result has been taken in S_OUT. Reset (synchronous, active low)
// clears the state, sets cos to one and loads the register reset values.
// ----------------------------------------------------------------------------
module rigid_body_euler_integrator #(
    parameter int FRAC_BITS    = rbei_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = rbei_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_cmd,
    input  logic signed [31:0]  i_vec_x,
    input  logic signed [31:0]  i_vec_y,
    input  logic signed [31:0]  i_contact_x,
    input  logic signed [31:0]  i_contact_y,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_report_x,
    output logic signed [31:0]  o_report_y,
    output logic signed [31:0]  o_report_vel_x,
    output logic signed [31:0]  o_report_vel_y,
    output logic signed [31:0]  o_report_heading,
    output logic signed [31:0]  o_report_spin,
    output logic signed [17:0]  o_report_cos,
    output logic signed [17:0]  o_report_sin
);
    localparam int ACC = rbei_pkg::ACC;

    // Operation codes of the step sequencer.
    typedef enum logic [3:0] {
        OP_AX, OP_AY, OP_VX, OP_VY, OP_PX, OP_PY, OP_HD, OP_TURN, OP_DECAY,
        OP_CR1, OP_CR2, OP_IVX, OP_IVY, OP_ISP
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_ROT   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    t_op    r_op;

    logic [30:0] r_inv_mass, r_inv_inertia;
    logic [16:0] r_time_step;
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_hd, r_sp, r_fx, r_fy;
    logic signed [31:0] r_ax, r_ay, r_sp_old;
    logic signed [17:0] r_cos, r_sin;
    logic signed [31:0] r_ivx, r_ivy, r_icx, r_icy;
    logic signed [ACC-1:0] r_cr1;

    rbei_pkg::t_mul_req w_req;
    rbei_pkg::t_mul_rsp w_rsp;
    logic signed [ACC-1:0] w_q, w_cr;
    logic [31:0] w_cr_sat;
    logic signed [ACC-1:0] w_mag;
    logic        w_cdone;
    logic signed [17:0] w_ccos, w_csin;

    // A configuration write takes priority over an item in the idle state.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_valid     = (r_state == S_OUT);

    // Operand select for the shared multiplier.
    always_comb begin
        w_req.start    = (r_state == S_ISSUE);
        w_req.a_signed = 1'b1;
        w_req.a        = '0;
        w_req.b        = '0;
        case (r_op)
            OP_AX:    begin w_req.a = r_fx; w_req.b = {1'b0, r_inv_mass}; end
            OP_AY:    begin w_req.a = r_fy; w_req.b = {1'b0, r_inv_mass}; end
            OP_VX:    begin w_req.a = r_ax; w_req.b = {15'd0, r_time_step}; end
            OP_VY:    begin w_req.a = r_ay; w_req.b = {15'd0, r_time_step}; end
            OP_PX:    begin w_req.a = r_vx; w_req.b = {15'd0, r_time_step}; end
            OP_PY:    begin w_req.a = r_vy; w_req.b = {15'd0, r_time_step}; end
            OP_HD:    begin w_req.a = r_sp; w_req.b = {15'd0, r_time_step}; end
            OP_TURN:  begin w_req.a = r_hd; w_req.b = rbei_pkg::TURN_SCALE; end
            OP_DECAY: begin
                w_req.a = r_sp_old[31] ? -r_sp_old : r_sp_old;
                w_req.b = rbei_pkg::SPIN_DECAY;
                w_req.a_signed = 1'b0;
            end
            OP_CR1:   begin w_req.a = r_icx; w_req.b = r_ivy; end
            OP_CR2:   begin w_req.a = r_icy; w_req.b = r_ivx; end
            OP_IVX:   begin w_req.a = r_ivx; w_req.b = {1'b0, r_inv_mass}; end
            OP_IVY:   begin w_req.a = r_ivy; w_req.b = {1'b0, r_inv_mass}; end
            OP_ISP:   begin w_req.a = r_cr1[31:0]; w_req.b = {1'b0, r_inv_inertia}; end
            default:  begin w_req.a = '0; w_req.b = '0; end
        endcase
        // Both cross-product operands are signed.
        if (r_op == OP_CR1 || r_op == OP_CR2) w_req.a_signed = 1'b1;
    end

    rbei_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // The multiplier returns the exact product for every operation.
    logic signed [ACC-1:0] w_prod;
    assign w_prod   = w_rsp.prod;
    assign w_q      = w_prod >>> FRAC_BITS;
    assign w_mag    = w_rsp.prod >>> 16;
    assign w_cr_sat = rbei_pkg::sat32(r_cr1 - w_q);
    assign w_cr     = $signed({{(ACC-32){w_cr_sat[31]}}, w_cr_sat});

    rbei_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_WAIT && w_rsp.done &&
        r_op == OP_TURN), .i_angle(w_q[31:0]), .o_done(w_cdone), .o_cos(w_ccos),
        .o_sin(w_csin));

    // Step sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_op          <= OP_AX;
            r_inv_mass    <= rbei_pkg::INV_MASS_RST;
            r_inv_inertia <= rbei_pkg::INV_INERTIA_RST;
            r_time_step   <= rbei_pkg::TIME_STEP_RST;
            r_px <= '0; r_py <= '0; r_vx <= '0; r_vy <= '0;
            r_hd <= '0; r_sp <= '0; r_fx <= '0; r_fy <= '0;
            r_cos <= 18'sd65536; r_sin <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            rbei_pkg::REG_INV_MASS:    r_inv_mass    <= i_cfg_data[30:0];
                            rbei_pkg::REG_INV_INERTIA: r_inv_inertia <= i_cfg_data[30:0];
                            rbei_pkg::REG_TIME_STEP:   r_time_step   <= i_cfg_data[16:0];
                            default: ;
                        endcase
                    end else if (i_valid) begin
                        r_ivx <= i_vec_x; r_ivy <= i_vec_y;
                        r_icx <= i_contact_x; r_icy <= i_contact_y;
                        case (i_cmd)
                            rbei_pkg::CMD_TICK: begin
                                r_op <= OP_AX; r_state <= S_ISSUE; r_sp_old <= r_sp;
                            end
                            rbei_pkg::CMD_FORCE: begin
                                r_fx <= rbei_pkg::sat32(ACC'(r_fx) + ACC'(i_vec_x));
                                r_fy <= rbei_pkg::sat32(ACC'(r_fy) + ACC'(i_vec_y));
                                r_state <= S_OUT;
                            end
                            rbei_pkg::CMD_IMPULSE: begin
                                r_op <= OP_CR1; r_state <= S_ISSUE;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_state <= S_ISSUE;
                        case (r_op)
                            OP_AX: begin r_ax <= rbei_pkg::sat32(w_q); r_op <= OP_AY; end
                            OP_AY: begin r_ay <= rbei_pkg::sat32(w_q); r_op <= OP_VX; end
                            OP_VX: begin
                                r_vx <= rbei_pkg::sat32(ACC'(r_vx) +
                                        ACC'($signed(rbei_pkg::sat32(w_q))));
                                r_op <= OP_VY;
                            end
                            OP_VY: begin
                                r_vy <= rbei_pkg::sat32(ACC'(r_vy) +
                                        ACC'($signed(rbei_pkg::sat32(w_q))));
                                r_op <= OP_PX;
                            end
                            OP_PX: begin
                                r_px <= rbei_pkg::sat32(ACC'(r_px) +
                                        ACC'($signed(rbei_pkg::sat32(w_q))));
                                r_op <= OP_PY;
                            end
                            OP_PY: begin
                                r_py <= rbei_pkg::sat32(ACC'(r_py) +
                                        ACC'($signed(rbei_pkg::sat32(w_q))));
                                r_op <= OP_HD;
                            end
                            OP_HD: begin
                                r_hd <= rbei_pkg::sat32(ACC'(r_hd) +
                                        ACC'($signed(rbei_pkg::sat32(w_q))));
                                r_op <= OP_TURN;
                            end
                            OP_TURN: r_state <= S_ROT;
                            OP_DECAY: begin
                                r_sp <= r_sp_old[31] ? -w_mag[31:0] : w_mag[31:0];
                                r_fx <= '0; r_fy <= '0;
                                r_state <= S_OUT;
                            end
                            OP_CR1: begin r_cr1 <= w_q; r_op <= OP_CR2; end
                            OP_CR2: begin r_cr1 <= w_cr; r_op <= OP_IVX; end
                            OP_IVX: begin
                                r_vx <= rbei_pkg::sat32(ACC'(r_vx) +
                                        ACC'($signed(rbei_pkg::sat32(w_q))));
                                r_op <= OP_IVY;
                            end
                            OP_IVY: begin
                                r_vy <= rbei_pkg::sat32(ACC'(r_vy) +
                                        ACC'($signed(rbei_pkg::sat32(w_q))));
                                r_op <= OP_ISP;
                            end
                            OP_ISP: begin
                                r_sp <= rbei_pkg::sat32(ACC'(r_sp) +
                                        ACC'($signed(rbei_pkg::sat32(w_q))));
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_ROT: begin
                    if (w_cdone) begin
                        r_cos <= w_ccos; r_sin <= w_csin;
                        r_op <= OP_DECAY; r_state <= S_ISSUE;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_report_x       = r_px;
    assign o_report_y       = r_py;
    assign o_report_vel_x   = r_vx;
    assign o_report_vel_y   = r_vy;
    assign o_report_heading = r_hd;
    assign o_report_spin    = r_sp;
    assign o_report_cos     = r_cos;
    assign o_report_sin     = r_sin;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while a result waits");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_report_x))
        else $error("result changed while stalled");

endmodule
